FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file rrpc_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define RRPC_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rrpc checker: implication failed");

// Implication whose consequent is checked after the delay given by n.
`define RRPC_ASSERT_DELAY(lbl, ante, n, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##(n) (cons)) \
		else $error("rrpc checker: delayed implication failed");

`endif

FILE: rtl/rrpc_pkg.sv
// ----------------------------------------------------------------------------
// rrpc_pkg
// Widths, register codes and shared types of the rounded rectangle classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrpc_pkg;

	localparam int COORD_BITS     = 16;   // coordinate mask width, 8..16
	localparam int DIM_BITS       = 16;
	localparam int POS_BITS       = DIM_BITS + 2;
	localparam int THICK_BITS     = 8;
	localparam int ARGB_BITS      = 32;
	localparam int FILL_BITS      = 25;
	localparam int FILL_EN_BIT    = 24;
	localparam int RGB_BITS       = 24;
	localparam int SQ_BITS        = 2 * DIM_BITS;
	localparam int DIST_BITS      = SQ_BITS + 1;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 32;
	localparam int LATENCY        = 5;

	localparam logic [7:0] OPAQUE_ALPHA = 8'hFF;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_RECT_LEFT    = 3'd0,
		REG_RECT_TOP     = 3'd1,
		REG_RECT_WIDTH   = 3'd2,
		REG_RECT_HEIGHT  = 3'd3,
		REG_BORDER_THICK = 3'd4,
		REG_CORNER_RAD   = 3'd5,
		REG_BORDER_ARGB  = 3'd6,
		REG_FILL_SETTING = 3'd7
	} cfg_reg_t;

	typedef logic signed [POS_BITS-1:0] pos_t;

	typedef struct packed {
		logic [DIM_BITS-1:0]   rect_left;
		logic [DIM_BITS-1:0]   rect_top;
		logic [DIM_BITS-1:0]   rect_width;
		logic [DIM_BITS-1:0]   rect_height;
		logic [THICK_BITS-1:0] border_thickness;
		logic [DIM_BITS-1:0]   corner_radius;
		logic [ARGB_BITS-1:0]  border_argb;
		logic [FILL_BITS-1:0]  fill_setting;
	} cfg_t;

	// Geometry of one pixel, handed from the front stages to the shading stages.
	typedef struct packed {
		logic                in_rect;
		logic                corner;
		logic                band;
		logic [DIM_BITS-1:0] dx;
		logic [DIM_BITS-1:0] dy;
		logic [DIM_BITS-1:0] r;
		logic [DIM_BITS-1:0] ir;
	} geo_t;

	function automatic logic [DIM_BITS-1:0] mask_coord(input logic [DIM_BITS-1:0] v);
		logic [DIM_BITS-1:0] m;
		m = '0;
		m[COORD_BITS-1:0] = v[COORD_BITS-1:0];
		return m;
	endfunction

	function automatic pos_t to_pos(input logic [DIM_BITS-1:0] v);
		return pos_t'({2'b00, v});
	endfunction

endpackage

FILE: rtl/rrpc_geom.sv
// ----------------------------------------------------------------------------
// rrpc_geom
// Front three stages: bounds test and radius clamp, corner centers and band
// edges, corner selection with per-axis distance to the corner center.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrpc_geom (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic [rrpc_pkg::DIM_BITS-1:0]  pixel_x,
	input  logic [rrpc_pkg::DIM_BITS-1:0]  pixel_y,
	input  rrpc_pkg::cfg_t                 cfg,
	output logic                           geo_valid,
	output rrpc_pkg::geo_t                 geo
);

	// stage 1
	logic                          valid_s1;
	logic [rrpc_pkg::DIM_BITS-1:0] px_s1, py_s1, r_s1;
	logic                          in_rect_s1;

	// stage 2
	logic                          valid_s2;
	logic [rrpc_pkg::DIM_BITS-1:0] px_s2, py_s2, r_s2, ir_s2;
	logic                          in_rect_s2;
	rrpc_pkg::pos_t                lcx_s2, rcx_s2, tcy_s2, bcy_s2;
	rrpc_pkg::pos_t                edge_l_s2, edge_r_s2, edge_t_s2, edge_b_s2;

	// stage 3
	logic                          valid_s3;
	rrpc_pkg::geo_t                geo_s3;

	rrpc_pkg::pos_t                x_c, y_c, w_c, h_c, pxe_c, pye_c;
	logic [rrpc_pkg::DIM_BITS-1:0] px_c, py_c, r_c, hw_c, hh_c, bw_c;
	logic                          in_rect_c;

	always_comb begin
		px_c  = rrpc_pkg::mask_coord(pixel_x);
		py_c  = rrpc_pkg::mask_coord(pixel_y);
		pxe_c = rrpc_pkg::to_pos(px_c);
		pye_c = rrpc_pkg::to_pos(py_c);
		x_c   = rrpc_pkg::to_pos(rrpc_pkg::mask_coord(cfg.rect_left));
		y_c   = rrpc_pkg::to_pos(rrpc_pkg::mask_coord(cfg.rect_top));
		w_c   = rrpc_pkg::to_pos(cfg.rect_width);
		h_c   = rrpc_pkg::to_pos(cfg.rect_height);
		in_rect_c = (pxe_c >= x_c) && (pxe_c < x_c + w_c) &&
			(pye_c >= y_c) && (pye_c < y_c + h_c);
		hw_c = cfg.rect_width >> 1;
		hh_c = cfg.rect_height >> 1;
		r_c  = cfg.corner_radius;
		if (r_c > hw_c) begin
			r_c = hw_c;
		end
		if (r_c > hh_c) begin
			r_c = hh_c;
		end
		bw_c = rrpc_pkg::DIM_BITS'(cfg.border_thickness);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		px_s1      <= px_c;
		py_s1      <= py_c;
		in_rect_s1 <= in_rect_c;
		r_s1       <= r_c;
	end

	// Corner centers and straight band edges; the bottom and right ones can
	// go negative for tiny rectangles, hence the signed width.
	always_ff @(posedge clk) begin
		px_s2      <= px_s1;
		py_s2      <= py_s1;
		in_rect_s2 <= in_rect_s1;
		r_s2       <= r_s1;
		ir_s2      <= (r_s1 > bw_c) ? r_s1 - bw_c : '0;
		lcx_s2     <= x_c + rrpc_pkg::to_pos(r_s1);
		rcx_s2     <= x_c + w_c - rrpc_pkg::to_pos(r_s1) - rrpc_pkg::pos_t'(1);
		tcy_s2     <= y_c + rrpc_pkg::to_pos(r_s1);
		bcy_s2     <= y_c + h_c - rrpc_pkg::to_pos(r_s1) - rrpc_pkg::pos_t'(1);
		edge_l_s2  <= x_c + rrpc_pkg::to_pos(bw_c);
		edge_r_s2  <= x_c + w_c - rrpc_pkg::to_pos(bw_c);
		edge_t_s2  <= y_c + rrpc_pkg::to_pos(bw_c);
		edge_b_s2  <= y_c + h_c - rrpc_pkg::to_pos(bw_c);
	end

	rrpc_pkg::pos_t px2_c, py2_c, dxf_c, dyf_c;
	logic           left_c, right_c, upper_c, lower_c;
	rrpc_pkg::geo_t geo_c;

	// Within a corner square the distance along each axis never exceeds the
	// radius, so the low bits hold it exactly.
	always_comb begin
		px2_c   = rrpc_pkg::to_pos(px_s2);
		py2_c   = rrpc_pkg::to_pos(py_s2);
		left_c  = px2_c < lcx_s2;
		right_c = px2_c > rcx_s2;
		upper_c = py2_c < tcy_s2;
		lower_c = py2_c > bcy_s2;
		dxf_c   = left_c ? lcx_s2 - px2_c : px2_c - rcx_s2;
		dyf_c   = upper_c ? tcy_s2 - py2_c : py2_c - bcy_s2;
		geo_c.in_rect = in_rect_s2;
		geo_c.corner  = (left_c || right_c) && (upper_c || lower_c);
		geo_c.band    = (cfg.border_thickness != '0) &&
			(py2_c < edge_t_s2 || py2_c >= edge_b_s2 ||
			 px2_c < edge_l_s2 || px2_c >= edge_r_s2);
		geo_c.dx = dxf_c[rrpc_pkg::DIM_BITS-1:0];
		geo_c.dy = dyf_c[rrpc_pkg::DIM_BITS-1:0];
		geo_c.r  = r_s2;
		geo_c.ir = ir_s2;
	end

	always_ff @(posedge clk) begin
		geo_s3 <= geo_c;
	end

	assign geo_valid = valid_s3;
	assign geo       = geo_s3;

endmodule

FILE: rtl/rrpc_shade.sv
// ----------------------------------------------------------------------------
// rrpc_shade
// Back two stages: squares of the corner distances and radii, then the curve
// test and the choice of border, fill or nothing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrpc_shade (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            geo_valid,
	input  rrpc_pkg::geo_t                  geo,
	input  rrpc_pkg::cfg_t                  cfg,
	output logic                            done,
	output logic                            write_pixel,
	output logic                            on_border,
	output logic [rrpc_pkg::ARGB_BITS-1:0]  pixel_argb
);

	logic                         valid_s4;
	logic                         in_rect_s4, corner_s4, band_s4;
	logic [rrpc_pkg::SQ_BITS-1:0] dxsq_s4, dysq_s4, rsq_s4, irsq_s4;

	logic                           valid_s5;
	logic                           write_s5, border_s5;
	logic [rrpc_pkg::ARGB_BITS-1:0] argb_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s4 <= geo_valid;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		in_rect_s4 <= geo.in_rect;
		corner_s4  <= geo.corner;
		band_s4    <= geo.band;
		dxsq_s4    <= geo.dx * geo.dx;
		dysq_s4    <= geo.dy * geo.dy;
		rsq_s4     <= geo.r * geo.r;
		irsq_s4    <= geo.ir * geo.ir;
	end

	logic [rrpc_pkg::DIST_BITS-1:0] dist_c;
	logic                           in_curve_c, in_ring_c, draw_c, fill_on_c;
	logic                           paint_border_c, paint_fill_c;
	logic [rrpc_pkg::ARGB_BITS-1:0] argb_c;

	always_comb begin
		draw_c     = cfg.border_thickness != '0;
		fill_on_c  = cfg.fill_setting[rrpc_pkg::FILL_EN_BIT];
		dist_c     = {1'b0, dxsq_s4} + {1'b0, dysq_s4};
		in_curve_c = dist_c < {1'b0, rsq_s4};
		in_ring_c  = draw_c && (dist_c >= {1'b0, irsq_s4});
		paint_border_c = 1'b0;
		paint_fill_c   = 1'b0;
		if (in_rect_s4) begin
			if (corner_s4) begin
				if (in_curve_c) begin
					paint_border_c = in_ring_c;
					paint_fill_c   = !in_ring_c && fill_on_c;
				end
			end else if (band_s4) begin
				paint_border_c = 1'b1;
			end else begin
				paint_fill_c = fill_on_c;
			end
		end
		if (paint_border_c) begin
			argb_c = cfg.border_argb;
		end else if (paint_fill_c) begin
			argb_c = {rrpc_pkg::OPAQUE_ALPHA, cfg.fill_setting[rrpc_pkg::RGB_BITS-1:0]};
		end else begin
			argb_c = '0;
		end
	end

	always_ff @(posedge clk) begin
		write_s5  <= paint_border_c || paint_fill_c;
		border_s5 <= paint_border_c;
		argb_s5   <= argb_c;
	end

	assign done        = valid_s5;
	assign write_pixel = write_s5;
	assign on_border   = border_s5;
	assign pixel_argb  = argb_s5;

endmodule

FILE: rtl/rounded_rect_pixel_classifier_core.sv
// ----------------------------------------------------------------------------
// rounded_rect_pixel_classifier_core
// Classifies pixel coordinates against a rounded rectangle with border band.
// ----------------------------------------------------------------------------
// One pixel is taken on every clock at which start is high; busy stays low,
// as the five-stage pipeline never stalls. The result appears with done high
// at the output of the last stage and lasts one cycle; the receiver must
// take it then. The stages, in order, are bounds and radius clamp, corner
// centers, corner selection, squaring and curve test. Configuration
// writes take effect at once and must only happen while no pixel is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rounded_rect_pixel_classifier_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [rrpc_pkg::DIM_BITS-1:0]        pixel_x,
	input  logic [rrpc_pkg::DIM_BITS-1:0]        pixel_y,
	input  logic                                 write_enable,
	input  logic [rrpc_pkg::CFG_INDEX_BITS-1:0]  reg_index,
	input  logic [rrpc_pkg::CFG_DATA_BITS-1:0]   write_data,
	output logic                                 done,
	output logic                                 write_pixel,
	output logic                                 on_border,
	output logic [rrpc_pkg::ARGB_BITS-1:0]       pixel_argb
);

	rrpc_pkg::cfg_t cfg_q;
	rrpc_pkg::geo_t geo;
	logic           geo_valid;
	logic           accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (write_enable) begin
			unique case (rrpc_pkg::cfg_reg_t'(reg_index))
				rrpc_pkg::REG_RECT_LEFT:
					cfg_q.rect_left <= write_data[rrpc_pkg::DIM_BITS-1:0];
				rrpc_pkg::REG_RECT_TOP:
					cfg_q.rect_top <= write_data[rrpc_pkg::DIM_BITS-1:0];
				rrpc_pkg::REG_RECT_WIDTH:
					cfg_q.rect_width <= write_data[rrpc_pkg::DIM_BITS-1:0];
				rrpc_pkg::REG_RECT_HEIGHT:
					cfg_q.rect_height <= write_data[rrpc_pkg::DIM_BITS-1:0];
				rrpc_pkg::REG_BORDER_THICK:
					cfg_q.border_thickness <= write_data[rrpc_pkg::THICK_BITS-1:0];
				rrpc_pkg::REG_CORNER_RAD:
					cfg_q.corner_radius <= write_data[rrpc_pkg::DIM_BITS-1:0];
				rrpc_pkg::REG_BORDER_ARGB:
					cfg_q.border_argb <= write_data[rrpc_pkg::ARGB_BITS-1:0];
				rrpc_pkg::REG_FILL_SETTING:
					cfg_q.fill_setting <= write_data[rrpc_pkg::FILL_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	assign busy   = 1'b0;
	assign accept = start && !busy;

	rrpc_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.cfg       (cfg_q),
		.geo_valid (geo_valid),
		.geo       (geo)
	);

	rrpc_shade u_shade (
		.clk         (clk),
		.arst_n      (arst_n),
		.geo_valid   (geo_valid),
		.geo         (geo),
		.cfg         (cfg_q),
		.done        (done),
		.write_pixel (write_pixel),
		.on_border   (on_border),
		.pixel_argb  (pixel_argb)
	);

endmodule

FILE: rtl/rrpc_checker.sv
// ----------------------------------------------------------------------------
// rrpc_checker
// Port-level checks of the classifier: fixed latency and result consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rrpc_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 start,
	input logic                                 busy,
	input logic                                 done,
	input logic                                 write_pixel,
	input logic                                 on_border,
	input logic [rrpc_pkg::ARGB_BITS-1:0]       pixel_argb
);

	// every transfer gives exactly one result, at the delay set by LATENCY
	`RRPC_ASSERT_DELAY(a_result_follows, start && !busy, rrpc_pkg::LATENCY, done)
	`RRPC_ASSERT_DELAY(a_no_spurious, !(start && !busy), rrpc_pkg::LATENCY, !done)
	`RRPC_ASSERT_IMPLY(a_border_writes, done && on_border, write_pixel)
	`RRPC_ASSERT_IMPLY(a_idle_black, done && !write_pixel, pixel_argb == '0 && !on_border)

endmodule

bind rounded_rect_pixel_classifier_core rrpc_checker u_rrpc_checker (.*);
